@@ sv/mtfcs_pkg.sv @@
// Shared types and character constants for the formatting-code stripper.
package mtfcs_pkg;

    // Scanner mode carried from one byte to the next.
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_SKIP   = 2'd2,
        MODE_STACK  = 2'd3
    } t_scan_mode;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;  // '{'
    localparam logic [7:0] CH_RBRACE    = 8'h7D;  // '}'
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_PARA      = 8'h50;  // 'P'
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STACK     = 8'h53;  // 'S'
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Outcome of decoding one byte.
    typedef struct packed {
        logic       emit;       // a result item is produced
        logic       have;       // the result carries a byte
        logic [7:0] byte_val;   // the byte, zero when none
        t_scan_mode next_mode;
    } t_dec_result;

endpackage

@@ sv/mtfcs_if.sv @@
// Valid/ready channel interfaces for the input bytes and the output items.
interface mtfcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_char;

    modport source (output valid, output char_in, output last_char, input ready);
    modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface mtfcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       char_valid;
    logic       end_of_text;

    modport source (output valid, output char_out, output char_valid,
                    output end_of_text, input ready);
    modport sink   (input valid, input char_out, input char_valid,
                    input end_of_text, output ready);
endinterface

@@ sv/mtfcs_decode.sv @@
// Combinational byte decoder: one scanner step for one input byte.
module mtfcs_decode (
    input  mtfcs_pkg::t_scan_mode  i_mode,
    input  logic [7:0]             i_char,
    input  logic                   i_last,
    output mtfcs_pkg::t_dec_result o_result
);

    logic                   w_have;
    logic [7:0]             w_byte;
    mtfcs_pkg::t_scan_mode  w_mode;

    always_comb begin
        w_have = 1'b0;
        w_byte = 8'h00;
        w_mode = i_mode;
        unique case (i_mode)
            mtfcs_pkg::MODE_NORMAL: begin
                if (i_char == mtfcs_pkg::CH_LBRACE || i_char == mtfcs_pkg::CH_RBRACE) begin
                    w_have = 1'b0;
                end else if (i_char == mtfcs_pkg::CH_BACKSLASH) begin
                    // A backslash that ends the text is kept as itself.
                    if (i_last) begin
                        w_have = 1'b1;
                        w_byte = i_char;
                    end else begin
                        w_mode = mtfcs_pkg::MODE_ESCAPE;
                    end
                end else begin
                    w_have = 1'b1;
                    w_byte = i_char;
                end
            end
            mtfcs_pkg::MODE_ESCAPE: begin
                w_mode = mtfcs_pkg::MODE_NORMAL;
                case (i_char)
                    mtfcs_pkg::CH_PARA: begin
                        w_have = 1'b1;
                        w_byte = mtfcs_pkg::CH_NEWLINE;
                    end
                    mtfcs_pkg::CH_TILDE: begin
                        w_have = 1'b1;
                        w_byte = mtfcs_pkg::CH_SPACE;
                    end
                    "L", "l", "O", "o", "K", "k": begin
                        w_have = 1'b0;
                    end
                    "f", "F", "C", "c", "H", "W", "T", "Q", "A", "p": begin
                        w_mode = mtfcs_pkg::MODE_SKIP;
                    end
                    mtfcs_pkg::CH_STACK: begin
                        w_mode = mtfcs_pkg::MODE_STACK;
                    end
                    default: begin
                        w_have = 1'b1;
                        w_byte = i_char;
                    end
                endcase
            end
            mtfcs_pkg::MODE_SKIP: begin
                if (i_char == mtfcs_pkg::CH_SEMI) begin
                    w_mode = mtfcs_pkg::MODE_NORMAL;
                end
            end
            mtfcs_pkg::MODE_STACK: begin
                if (i_char == mtfcs_pkg::CH_SEMI) begin
                    w_mode = mtfcs_pkg::MODE_NORMAL;
                end else begin
                    w_have = 1'b1;
                    if (i_char == mtfcs_pkg::CH_CARET || i_char == mtfcs_pkg::CH_HASH) begin
                        w_byte = mtfcs_pkg::CH_SLASH;
                    end else begin
                        w_byte = i_char;
                    end
                end
            end
            default: begin
                w_mode = mtfcs_pkg::MODE_NORMAL;
            end
        endcase

        // The last byte always closes the text and restarts the scanner.
        if (i_last) begin
            w_mode = mtfcs_pkg::MODE_NORMAL;
        end

        o_result.emit      = w_have | i_last;
        o_result.have      = w_have;
        o_result.byte_val  = w_byte;
        o_result.next_mode = w_mode;
    end

endmodule

@@ sv/mtext_format_code_stripper.sv @@
// Top level of the text formatting-code stripper.
// The block takes one text byte per item and emits the plain text with all
// formatting codes removed, at a sustained rate of one byte per clock cycle
// while the downstream side does not stall. Each accepted byte lands in an
// input register. In the next cycle the decoder looks at it together with the
// two-bit scanner mode. If the byte yields text or ends the text, the decoder
// writes a result item into the output register as soon as that register is
// free; while the downstream side stalls, the byte waits in the input
// register. The rate is set by the scanner mode register, which is updated
// once per byte. Bytes that produce nothing (braces, escape codes, skipped
// runs) are consumed without a result item. The byte flagged as the last one
// always gives exactly one result item with end_of_text set. That item
// carries a byte when the last byte produces one, and otherwise has
// char_valid low with char_out zero. The output register and the input
// register are parted, so one more byte is taken into the input register
// while a finished result still waits for the downstream side.
module mtext_format_code_stripper (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mtfcs_in_if.sink          i_in,
    mtfcs_out_if.source       o_out
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    // Scanner state.
    mtfcs_pkg::t_scan_mode r_mode;

    // Result register.
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_cv;
    logic       r_out_eot;

    mtfcs_pkg::t_dec_result n_dec;

    logic w_out_free;
    logic w_advance;
    logic w_in_ready;

    // The decoder works on the byte held in the input register.
    mtfcs_decode u_decode (
        .i_mode   (r_mode),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_result (n_dec)
    );

    // The result register can take a new item when empty or being drained.
    assign w_out_free = !r_out_valid || o_out.ready;
    // The held byte is consumed whenever its result has a place to go.
    assign w_advance  = r_in_valid && w_out_free;
    assign w_in_ready = !r_in_valid || w_out_free;

    assign i_in.ready        = w_in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.char_out    = r_out_char;
    assign o_out.char_valid  = r_out_cv;
    assign o_out.end_of_text = r_out_eot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= mtfcs_pkg::MODE_NORMAL;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_mode <= n_dec.next_mode;
            end
            if (w_out_free) begin
                r_out_valid <= w_advance && n_dec.emit;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in_char <= i_in.char_in;
            r_in_last <= i_in.last_char;
        end
        if (w_advance && n_dec.emit) begin
            r_out_char <= n_dec.byte_val;
            r_out_cv   <= n_dec.have;
            r_out_eot  <= r_in_last;
        end
    end

endmodule

@@ sv/mtfcs_checker.sv @@
// Port-level assertions for the stripper and the bind that attaches them.
module mtfcs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_cv,
    input logic       i_out_eot
);

    // No result item is offered in the cycle after a reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // Every result item either carries a byte or closes the text.
    a_item_useful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_cv || i_out_eot))
        else $error("result item with neither byte nor end mark");

    // An item without a byte carries a zero byte field.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_cv) |-> (i_out_char == 8'h00))
        else $error("empty result item with nonzero byte");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_char) && $stable(i_out_cv) && $stable(i_out_eot)))
        else $error("stalled result item changed");

endmodule

bind mtext_format_code_stripper mtfcs_checker u_mtfcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.char_out),
    .i_out_cv    (o_out.char_valid),
    .i_out_eot   (o_out.end_of_text)
);

@@ tb/tb_mtext_format_code_stripper.sv @@
// Self-checking testbench for the formatting-code stripper with a scoreboard class.
module tb_mtext_format_code_stripper;

    // Escape letters that open a skipped argument run, and the toggle letters
    // that are simply dropped after a backslash.
    localparam string SKIP_LETTERS   = "fFCcHWTQAp";
    localparam string TOGGLE_LETTERS = "LlOoKk";

    // Number of random items to send, the cycles the receiver holds off once,
    // and the number of quiet cycles after which the run is declared hung.
    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;

    // One plain-text result item as the block should present it.
    typedef struct packed {
        logic [7:0] ch;
        logic       has_ch;
        logic       eot;
    } t_plain_item;

    // The scoreboard keeps its own copy of the scanner mode, works out the
    // plain-text result of every accepted byte and compares the output stream
    // against those predictions in order.
    class strip_scoreboard;
        mtfcs_pkg::t_scan_mode scan;
        t_plain_item           expected_plain[$];
        int                    errors;

        function new();
            scan   = mtfcs_pkg::MODE_NORMAL;
            errors = 0;
        endfunction

        static function bit letter_in(logic [7:0] c, string set);
            for (int i = 0; i < set.len(); i++)
                if (c == set[i]) return 1'b1;
            return 1'b0;
        endfunction

        // Predicts the result of one accepted byte and queues it when the
        // byte yields text or closes the text.
        function void note_byte(logic [7:0] c, logic last);
            t_plain_item item;
            item = '0;
            case (scan)
                mtfcs_pkg::MODE_NORMAL: begin
                    if (c == mtfcs_pkg::CH_LBRACE || c == mtfcs_pkg::CH_RBRACE) begin
                        // Grouping braces vanish.
                    end else if (c == mtfcs_pkg::CH_BACKSLASH) begin
                        if (last) begin
                            item.has_ch = 1'b1;
                            item.ch     = c;
                        end else begin
                            scan = mtfcs_pkg::MODE_ESCAPE;
                        end
                    end else begin
                        item.has_ch = 1'b1;
                        item.ch     = c;
                    end
                end
                mtfcs_pkg::MODE_ESCAPE: begin
                    scan = mtfcs_pkg::MODE_NORMAL;
                    if (c == mtfcs_pkg::CH_PARA) begin
                        item.has_ch = 1'b1;
                        item.ch     = mtfcs_pkg::CH_NEWLINE;
                    end else if (c == mtfcs_pkg::CH_TILDE) begin
                        item.has_ch = 1'b1;
                        item.ch     = mtfcs_pkg::CH_SPACE;
                    end else if (letter_in(c, TOGGLE_LETTERS)) begin
                        // Underline, overline and strike toggles vanish.
                    end else if (letter_in(c, SKIP_LETTERS)) begin
                        scan = mtfcs_pkg::MODE_SKIP;
                    end else if (c == mtfcs_pkg::CH_STACK) begin
                        scan = mtfcs_pkg::MODE_STACK;
                    end else begin
                        item.has_ch = 1'b1;
                        item.ch     = c;
                    end
                end
                mtfcs_pkg::MODE_SKIP: begin
                    if (c == mtfcs_pkg::CH_SEMI) scan = mtfcs_pkg::MODE_NORMAL;
                end
                default: begin
                    if (c == mtfcs_pkg::CH_SEMI) begin
                        scan = mtfcs_pkg::MODE_NORMAL;
                    end else begin
                        item.has_ch = 1'b1;
                        item.ch     = (c == mtfcs_pkg::CH_CARET || c == mtfcs_pkg::CH_HASH)
                                      ? mtfcs_pkg::CH_SLASH : c;
                    end
                end
            endcase
            if (last) scan = mtfcs_pkg::MODE_NORMAL;
            item.eot = last;
            if (item.has_ch || last) expected_plain.insert(expected_plain.size(), item);
        endfunction

        function void check_plain(logic [7:0] ch, logic has_ch, logic eot);
            t_plain_item want;
            if (expected_plain.size() == 0) begin
                $error("result item with none expected: char_out=%02h char_valid=%0b end_of_text=%0b",
                       ch, has_ch, eot);
                errors++;
                return;
            end
            want = expected_plain.pop_front();
            if (has_ch !== want.has_ch) begin
                $error("char_valid: expected %0b, actual %0b", want.has_ch, has_ch);
                errors++;
            end
            if (ch !== want.ch) begin
                $error("char_out: expected %02h, actual %02h", want.ch, ch);
                errors++;
            end
            if (eot !== want.eot) begin
                $error("end_of_text: expected %0b, actual %0b", want.eot, eot);
                errors++;
            end
        endfunction

        function int waiting();
            return expected_plain.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mtfcs_in_if  text_ch ();
    mtfcs_out_if plain_ch ();

    mtext_format_code_stripper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_ch),
        .o_out   (plain_ch)
    );

    strip_scoreboard sb = new();

    // Idling is switched on and off in phases so that both gapped traffic and
    // back-to-back stretches occur on either side.
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    int results_seen   = 0;
    int quiet_cycles   = 0;

    logic [7:0] text_q[$];

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Appends one byte to the text under construction.
    function automatic void add_byte(logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    // Monitors both channels at each rising edge. An item counts as moved when
    // valid and ready were both high; the values read here are the ones from
    // before this edge's updates, so the order of processes does not matter.
    // The same block runs the watchdog over cycles in which nothing moves.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (text_ch.valid && text_ch.ready)
                sb.note_byte(text_ch.char_in, text_ch.last_char);
            if (plain_ch.valid && plain_ch.ready) begin
                sb.check_plain(plain_ch.char_out, plain_ch.char_valid, plain_ch.end_of_text);
                results_seen <= results_seen + 1;
            end
            if ((text_ch.valid && text_ch.ready) || (plain_ch.valid && plain_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offers one byte after an optional gap and returns at the edge where the
    // block takes it. Valid is only lowered when a gap follows, so it never
    // drops and rises within the same time step.
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = sender_idles ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.char_in   <= c;
        text_ch.last_char <= last;
        do @(posedge i_clk); while (!text_ch.ready);
    endtask

    // Sends a whole text, flagging its final byte as the end of the text.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Builds one random text out of tokens that mirror real formatted text:
    // plain bytes, braces, simple escapes, skipped and stacking runs, unknown
    // escapes and raw noise. Some texts are cut short so that they end inside
    // an escape or a run.
    task automatic make_text();
        int         tokens;
        int         arg_len;
        logic [7:0] b;
        text_q.delete();
        tokens = $urandom_range(1, 8);
        for (int t = 0; t < tokens; t++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_byte(8'($urandom_range(32, 126)));
                4: add_byte($urandom_range(0, 1) ? mtfcs_pkg::CH_LBRACE : mtfcs_pkg::CH_RBRACE);
                5: begin
                    add_byte(mtfcs_pkg::CH_BACKSLASH);
                    case ($urandom_range(0, 5))
                        0: add_byte(mtfcs_pkg::CH_PARA);
                        1: add_byte(mtfcs_pkg::CH_TILDE);
                        2: add_byte(mtfcs_pkg::CH_BACKSLASH);
                        3: add_byte($urandom_range(0, 1) ? mtfcs_pkg::CH_LBRACE
                                                         : mtfcs_pkg::CH_RBRACE);
                        default: add_byte(
                            TOGGLE_LETTERS[$urandom_range(0, TOGGLE_LETTERS.len() - 1)]);
                    endcase
                end
                6: begin
                    add_byte(mtfcs_pkg::CH_BACKSLASH);
                    add_byte(SKIP_LETTERS[$urandom_range(0, SKIP_LETTERS.len() - 1)]);
                    arg_len = $urandom_range(0, 6);
                    for (int k = 0; k < arg_len; k++) begin
                        b = 8'($urandom_range(0, 255));
                        add_byte(b == mtfcs_pkg::CH_SEMI ? mtfcs_pkg::CH_BACKSLASH : b);
                    end
                    add_byte(mtfcs_pkg::CH_SEMI);
                end
                7: begin
                    add_byte(mtfcs_pkg::CH_BACKSLASH);
                    add_byte(mtfcs_pkg::CH_STACK);
                    arg_len = $urandom_range(0, 6);
                    for (int k = 0; k < arg_len; k++) begin
                        case ($urandom_range(0, 3))
                            0: b = mtfcs_pkg::CH_CARET;
                            1: b = mtfcs_pkg::CH_HASH;
                            default: b = 8'($urandom_range(0, 255));
                        endcase
                        add_byte(b == mtfcs_pkg::CH_SEMI ? mtfcs_pkg::CH_LBRACE : b);
                    end
                    add_byte(mtfcs_pkg::CH_SEMI);
                end
                8: begin
                    add_byte(mtfcs_pkg::CH_BACKSLASH);
                    add_byte(8'($urandom_range(0, 255)));
                end
                default: add_byte(8'($urandom_range(0, 255)));
            endcase
        end
        // A broken text stops at a random point inside its tokens.
        if ($urandom_range(0, 4) == 0)
            while (text_q.size() > 1 && $urandom_range(0, 2) != 0)
                text_q.delete(text_q.size() - 1);
    endtask

    // Receiver: while idling is on, stalls a random number of cycles before each
    // result item, and once, after a few hundred results, holds ready low for a
    // long stretch while the sender keeps offering bytes, so the block fills and
    // must push back on its input.
    initial begin
        int  stall;
        bit  held;
        held = 1'b0;
        plain_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held && results_seen >= 300) begin
                plain_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end
            if ($urandom_range(0, 49) == 0) receiver_idles = !receiver_idles;
            stall = receiver_idles ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                plain_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            plain_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!plain_ch.valid);
        end
    end

    // Sender and run control.
    initial begin
        int sent;
        text_ch.valid     <= 1'b0;
        text_ch.char_in   <= 8'h00;
        text_ch.last_char <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed texts. The first covers the extreme byte values, braces,
        // the newline and space escapes, escaped backslash and brace, a
        // dropped toggle, an unknown escape, and a final byte that yields no
        // text. The second holds a skipped run, a stacking run with caret and
        // hash, and ends on a run letter. Then a text that ends inside an
        // unterminated skipped run, and one made of a lone trailing backslash.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("{\\P\\~\\\\\\}\\k\\x}");
        send_text("\\C1;\\S^#;\\f");
        send_text("\\Wa");
        send_text("\\");

        // Random texts, mostly well formed, until the item budget is spent.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            make_text();
            if ($urandom_range(0, 7) == 0) sender_idles = !sender_idles;
            foreach (text_q[i])
                send_byte(text_q[i], i == text_q.size() - 1);
            sent += text_q.size();
        end
        text_ch.valid <= 1'b0;

        // Let every predicted result arrive, then give the block a few more
        // cycles in case anything stray is still on its way out.
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/mtfcs_pkg.sv
sv/mtfcs_if.sv
sv/mtfcs_decode.sv
sv/mtext_format_code_stripper.sv
sv/mtfcs_checker.sv
tb/tb_mtext_format_code_stripper.sv
